// ===== rtl/cmlex_pkg.sv =====
// Shared types and constants for the C-minus lexical scanner.
// Used by cmlex_core, cmlex_queue and cminus_lexical_scanner_unit; no dependencies.
`timescale 1ns / 1ps

package cmlex_pkg;

  localparam int MAX_LEXEME = 32;
  localparam int LINE_BITS = 16;
  localparam int CNT_BITS = $clog2(MAX_LEXEME + 2);
  localparam int KW_BYTES = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE    = 4'd0,
    S_IDENT   = 4'd1,
    S_NUMBER  = 4'd2,
    S_LT      = 4'd3,
    S_GT      = 4'd4,
    S_EQ      = 4'd5,
    S_BANG    = 4'd6,
    S_SLASH   = 4'd7,
    S_COMMENT = 4'd8,
    S_STAR    = 4'd9
  } scan_state_t;

  typedef enum logic [4:0] {
    K_ELSE   = 5'd0,
    K_IF     = 5'd1,
    K_INT    = 5'd2,
    K_RETURN = 5'd3,
    K_VOID   = 5'd4,
    K_WHILE  = 5'd5,
    K_ID     = 5'd6,
    K_NUM    = 5'd7,
    K_PLUS   = 5'd8,
    K_MINUS  = 5'd9,
    K_TIMES  = 5'd10,
    K_DIV    = 5'd11,
    K_LT     = 5'd12,
    K_LE     = 5'd13,
    K_GT     = 5'd14,
    K_GE     = 5'd15,
    K_ASSIGN = 5'd16,
    K_EQ     = 5'd17,
    K_NE     = 5'd18,
    K_SEMI   = 5'd19,
    K_COMMA  = 5'd20,
    K_LPAR   = 5'd21,
    K_RPAR   = 5'd22,
    K_LBRK   = 5'd23,
    K_RBRK   = 5'd24,
    K_LBRC   = 5'd25,
    K_RBRC   = 5'd26,
    K_EOF    = 5'd27,
    K_BAD    = 5'd28,
    K_OPEN   = 5'd29
  } token_kind_t;

  // Packed with the token kind in the lowest bits.
  typedef struct packed {
    logic        number_overflow;
    logic [31:0] number_value;
    logic        length_overflow;
    logic [5:0]  token_length;
    logic [15:0] token_line;
    token_kind_t token_kind;
  } token_t;

  localparam int TOKEN_BITS = $bits(token_t);
  localparam int TDATA_BITS = ((TOKEN_BITS + 7) / 8) * 8;

  // Up to two tokens produced by one source byte; the second is valid only with the first.
  typedef struct packed {
    logic   valid0;
    logic   valid1;
    token_t tok0;
    token_t tok1;
  } token_pair_t;

endpackage

// ===== rtl/cmlex_core.sv =====
// Scanner automaton: state registers and the combinational step for one source byte.
// Depends on cmlex_pkg.
`timescale 1ns / 1ps

module cmlex_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  logic [7:0]           char_in,
  input  logic                 is_end,
  output cmlex_pkg::token_pair_t pair
);

  localparam logic [cmlex_pkg::CNT_BITS-1:0] CNT_ONE = cmlex_pkg::CNT_BITS'(1);

  cmlex_pkg::scan_state_t                   scan_state, scan_state_next;
  logic [8*cmlex_pkg::KW_BYTES-1:0]         keyword_chars, keyword_chars_next;
  logic [cmlex_pkg::CNT_BITS-1:0]           lexeme_count, lexeme_count_next;
  logic [cmlex_pkg::LINE_BITS-1:0]          line_count, line_count_next;
  logic [cmlex_pkg::LINE_BITS-1:0]          start_line, start_line_next;
  logic [31:0]                              number_accum, number_accum_next;
  logic                                     number_sat, number_sat_next;

  logic                                     is_letter, is_digit;
  logic [35:0]                              num_prod;
  logic [31:0]                              digit_accum;
  logic                                     digit_sat;
  logic [cmlex_pkg::LINE_BITS-1:0]          line_inc;
  cmlex_pkg::token_t                        flush_tok, second_tok;
  logic                                     flush_v, use_flush, second_v;

  function automatic cmlex_pkg::token_t make_tok(
    input cmlex_pkg::token_kind_t          kind,
    input logic [cmlex_pkg::LINE_BITS-1:0] line,
    input logic [cmlex_pkg::CNT_BITS-1:0]  count,
    input logic [31:0]                     value,
    input logic                            vsat
  );
    cmlex_pkg::token_t t;
    logic [31:0] line32;
    logic [31:0] len32;
    line32 = 32'(line);
    if (32'(count) > 32'(cmlex_pkg::MAX_LEXEME)) begin
      len32 = 32'(cmlex_pkg::MAX_LEXEME);
    end else begin
      len32 = 32'(count);
    end
    t.token_kind = kind;
    t.token_line = line32[15:0];
    t.token_length = len32[5:0];
    t.length_overflow = 32'(count) > 32'(cmlex_pkg::MAX_LEXEME);
    t.number_value = value;
    t.number_overflow = vsat;
    return t;
  endfunction

  function automatic logic [8*cmlex_pkg::KW_BYTES-1:0] kw_text(input int j);
    logic [8*cmlex_pkg::KW_BYTES-1:0] r;
    case (j)
      0:       r = 48'h0000_6573_6c65;
      1:       r = 48'h0000_0000_6669;
      2:       r = 48'h0000_0074_6e69;
      3:       r = 48'h6e72_7574_6572;
      4:       r = 48'h0000_6469_6f76;
      default: r = 48'h0065_6c69_6877;
    endcase
    return r;
  endfunction

  function automatic int kw_len(input int j);
    int r;
    case (j)
      0:       r = 4;
      1:       r = 2;
      2:       r = 3;
      3:       r = 6;
      4:       r = 4;
      default: r = 5;
    endcase
    return r;
  endfunction

  // Bytes above the identifier's length are always zero, so a whole-word compare suffices.
  function automatic cmlex_pkg::token_kind_t ident_kind(
    input logic [8*cmlex_pkg::KW_BYTES-1:0] chars,
    input logic [cmlex_pkg::CNT_BITS-1:0]   count
  );
    cmlex_pkg::token_kind_t k;
    k = cmlex_pkg::K_ID;
    for (int j = cmlex_pkg::KW_BYTES - 1; j >= 0; j--) begin
      if (32'(count) == 32'(kw_len(j)) && chars == kw_text(j)) begin
        k = cmlex_pkg::token_kind_t'(5'(j));
      end
    end
    return k;
  endfunction

  function automatic cmlex_pkg::token_kind_t single_kind(input logic [7:0] c);
    cmlex_pkg::token_kind_t k;
    case (c)
      "+":     k = cmlex_pkg::K_PLUS;
      "-":     k = cmlex_pkg::K_MINUS;
      "*":     k = cmlex_pkg::K_TIMES;
      ";":     k = cmlex_pkg::K_SEMI;
      ",":     k = cmlex_pkg::K_COMMA;
      "(":     k = cmlex_pkg::K_LPAR;
      ")":     k = cmlex_pkg::K_RPAR;
      "[":     k = cmlex_pkg::K_LBRK;
      "]":     k = cmlex_pkg::K_RBRK;
      "{":     k = cmlex_pkg::K_LBRC;
      "}":     k = cmlex_pkg::K_RBRC;
      default: k = cmlex_pkg::K_BAD;
    endcase
    return k;
  endfunction

  assign is_letter = (char_in inside {["a":"z"], ["A":"Z"]});
  assign is_digit = (char_in inside {["0":"9"]});

  assign line_inc = (line_count != '1) ? line_count + 1'b1 : line_count;

  always_comb begin
    logic [31:0] base;
    base = (scan_state == cmlex_pkg::S_NUMBER) ? number_accum : 32'd0;
    num_prod = ({4'd0, base} << 3) + ({4'd0, base} << 1) + 36'(char_in - 8'h30);
    if (num_prod[35:32] != 4'd0) begin
      digit_accum = 32'hFFFF_FFFF;
      digit_sat = 1'b1;
    end else begin
      digit_accum = num_prod[31:0];
      digit_sat = (scan_state == cmlex_pkg::S_NUMBER) ? number_sat : 1'b0;
    end
  end

  // Token held by the current state, reported when a following byte or the end ends it.
  always_comb begin
    flush_v = 1'b1;
    flush_tok = make_tok(cmlex_pkg::K_DIV, start_line, CNT_ONE, 32'd0, 1'b0);
    case (scan_state)
      cmlex_pkg::S_IDENT: begin
        flush_tok = make_tok(ident_kind(keyword_chars, lexeme_count), start_line,
                             lexeme_count, 32'd0, 1'b0);
      end
      cmlex_pkg::S_NUMBER: begin
        flush_tok = make_tok(cmlex_pkg::K_NUM, start_line, lexeme_count,
                             number_accum, number_sat);
      end
      cmlex_pkg::S_LT: flush_tok = make_tok(cmlex_pkg::K_LT, start_line, CNT_ONE, 32'd0, 1'b0);
      cmlex_pkg::S_GT: flush_tok = make_tok(cmlex_pkg::K_GT, start_line, CNT_ONE, 32'd0, 1'b0);
      cmlex_pkg::S_EQ: begin
        flush_tok = make_tok(cmlex_pkg::K_ASSIGN, start_line, CNT_ONE, 32'd0, 1'b0);
      end
      cmlex_pkg::S_BANG: begin
        flush_tok = make_tok(cmlex_pkg::K_BAD, start_line, CNT_ONE, 32'd0, 1'b0);
      end
      cmlex_pkg::S_SLASH: begin
        flush_tok = make_tok(cmlex_pkg::K_DIV, start_line, CNT_ONE, 32'd0, 1'b0);
      end
      cmlex_pkg::S_COMMENT, cmlex_pkg::S_STAR: begin
        flush_tok = make_tok(cmlex_pkg::K_OPEN, start_line, '0, 32'd0, 1'b0);
      end
      default: flush_v = 1'b0;
    endcase
  end

  always_comb begin
    scan_state_next = scan_state;
    keyword_chars_next = keyword_chars;
    lexeme_count_next = lexeme_count;
    line_count_next = line_count;
    start_line_next = start_line;
    number_accum_next = number_accum;
    number_sat_next = number_sat;
    use_flush = 1'b0;
    second_v = 1'b0;
    second_tok = make_tok(cmlex_pkg::K_EOF, line_count, '0, 32'd0, 1'b0);

    if (is_end) begin
      use_flush = flush_v;
      second_v = 1'b1;
      scan_state_next = cmlex_pkg::S_IDLE;
      keyword_chars_next = '0;
      lexeme_count_next = '0;
      line_count_next = cmlex_pkg::LINE_BITS'(1);
      start_line_next = cmlex_pkg::LINE_BITS'(1);
      number_accum_next = 32'd0;
      number_sat_next = 1'b0;
    end else if (scan_state == cmlex_pkg::S_IDENT && is_letter) begin
      for (int i = 0; i < cmlex_pkg::KW_BYTES; i++) begin
        if (32'(lexeme_count) == i) begin
          keyword_chars_next[8*i +: 8] = keyword_chars[8*i +: 8] | char_in;
        end
      end
      if (32'(lexeme_count) <= 32'(cmlex_pkg::MAX_LEXEME)) begin
        lexeme_count_next = lexeme_count + 1'b1;
      end
    end else if (scan_state == cmlex_pkg::S_NUMBER && is_digit) begin
      number_accum_next = digit_accum;
      number_sat_next = digit_sat;
      if (32'(lexeme_count) <= 32'(cmlex_pkg::MAX_LEXEME)) begin
        lexeme_count_next = lexeme_count + 1'b1;
      end
    end else if ((scan_state inside {cmlex_pkg::S_LT, cmlex_pkg::S_GT, cmlex_pkg::S_EQ,
                                     cmlex_pkg::S_BANG}) && char_in == "=") begin
      cmlex_pkg::token_kind_t k2;
      case (scan_state)
        cmlex_pkg::S_LT: k2 = cmlex_pkg::K_LE;
        cmlex_pkg::S_GT: k2 = cmlex_pkg::K_GE;
        cmlex_pkg::S_EQ: k2 = cmlex_pkg::K_EQ;
        default:         k2 = cmlex_pkg::K_NE;
      endcase
      second_v = 1'b1;
      second_tok = make_tok(k2, start_line, cmlex_pkg::CNT_BITS'(2), 32'd0, 1'b0);
      scan_state_next = cmlex_pkg::S_IDLE;
    end else if (scan_state == cmlex_pkg::S_SLASH && char_in == "*") begin
      scan_state_next = cmlex_pkg::S_COMMENT;
    end else if (scan_state == cmlex_pkg::S_COMMENT || scan_state == cmlex_pkg::S_STAR) begin
      if (char_in == "/" && scan_state == cmlex_pkg::S_STAR) begin
        scan_state_next = cmlex_pkg::S_IDLE;
      end else if (char_in == "*") begin
        scan_state_next = cmlex_pkg::S_STAR;
      end else begin
        scan_state_next = cmlex_pkg::S_COMMENT;
      end
      if (char_in == 8'h0A) begin
        line_count_next = line_inc;
      end
    end else begin
      // The pending token ends here and this byte starts from the idle state.
      use_flush = flush_v;
      scan_state_next = cmlex_pkg::S_IDLE;
      start_line_next = line_count;
      if (is_letter) begin
        scan_state_next = cmlex_pkg::S_IDENT;
        keyword_chars_next = 48'(char_in);
        lexeme_count_next = CNT_ONE;
      end else if (is_digit) begin
        scan_state_next = cmlex_pkg::S_NUMBER;
        lexeme_count_next = CNT_ONE;
        number_accum_next = digit_accum;
        number_sat_next = digit_sat;
      end else begin
        case (char_in)
          "<":                      scan_state_next = cmlex_pkg::S_LT;
          ">":                      scan_state_next = cmlex_pkg::S_GT;
          "=":                      scan_state_next = cmlex_pkg::S_EQ;
          "!":                      scan_state_next = cmlex_pkg::S_BANG;
          "/":                      scan_state_next = cmlex_pkg::S_SLASH;
          8'h20, 8'h09, 8'h0D:      scan_state_next = cmlex_pkg::S_IDLE;
          8'h0A:                    line_count_next = line_inc;
          default: begin
            second_v = 1'b1;
            second_tok = make_tok(single_kind(char_in), line_count, CNT_ONE, 32'd0, 1'b0);
          end
        endcase
      end
    end

    pair.valid0 = in_accept && (use_flush || second_v);
    pair.valid1 = in_accept && use_flush && second_v;
    pair.tok0 = use_flush ? flush_tok : second_tok;
    pair.tok1 = second_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= cmlex_pkg::S_IDLE;
      keyword_chars <= '0;
      lexeme_count <= '0;
      line_count <= cmlex_pkg::LINE_BITS'(1);
      start_line <= cmlex_pkg::LINE_BITS'(1);
      number_accum <= 32'd0;
      number_sat <= 1'b0;
    end else if (in_accept) begin
      scan_state <= scan_state_next;
      keyword_chars <= keyword_chars_next;
      lexeme_count <= lexeme_count_next;
      line_count <= line_count_next;
      start_line <= start_line_next;
      number_accum <= number_accum_next;
      number_sat <= number_sat_next;
    end
  end

endmodule

// ===== rtl/cmlex_queue.sv =====
// Small token queue: takes up to two tokens a cycle and delivers one a cycle while out_ready is high.
// Depends on cmlex_pkg.
`timescale 1ns / 1ps

module cmlex_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  cmlex_pkg::token_pair_t             pair,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cmlex_pkg::token_t                  out_tok,
  output logic [cmlex_pkg::LEVEL_BITS-1:0]   level
);

  cmlex_pkg::token_t                  mem [cmlex_pkg::QUEUE_DEPTH];
  logic [cmlex_pkg::PTR_BITS-1:0]     wr_ptr, wr_ptr_next;
  logic [cmlex_pkg::PTR_BITS-1:0]     rd_ptr, rd_ptr_next;
  logic [cmlex_pkg::LEVEL_BITS-1:0]   level_next;
  logic                               pop;
  logic [cmlex_pkg::PTR_BITS-1:0]     wr_ptr_plus;

  assign out_valid = (level != '0);
  assign out_tok = mem[rd_ptr];
  assign pop = out_valid && out_ready;
  assign wr_ptr_plus = wr_ptr + 1'b1;

  always_comb begin
    wr_ptr_next = wr_ptr + cmlex_pkg::PTR_BITS'(pair.valid0) + cmlex_pkg::PTR_BITS'(pair.valid1);
    rd_ptr_next = rd_ptr + cmlex_pkg::PTR_BITS'(pop);
    level_next = level + cmlex_pkg::LEVEL_BITS'(pair.valid0)
               + cmlex_pkg::LEVEL_BITS'(pair.valid1) - cmlex_pkg::LEVEL_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (pair.valid0) begin
      mem[wr_ptr] <= pair.tok0;
    end
    if (pair.valid1) begin
      mem[wr_ptr_plus] <= pair.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level <= level_next;
    end
  end

endmodule

// ===== rtl/cminus_lexical_scanner_unit.sv =====
// Top level of the C-minus lexical scanner: stream ports, scanner core and token queue.
// Depends on cmlex_pkg, cmlex_core and cmlex_queue.
// Output: a token is written into the token queue when the byte that completes it is accepted.
// Throughput: one source byte per cycle while the queue can hold two more tokens; a byte that
// completes two tokens is held in the four-entry token queue while they leave one at a time.
// Reset: synchronous; the scanner returns to its start state at line one and the queue empties.
`timescale 1ns / 1ps

module cminus_lexical_scanner_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // char_in[7:0]
  input  logic                             s_axis_tuser,  // is_end
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // token_kind[4:0], token_line[20:5], token_length[26:21], length_overflow[27],
  // number_value[59:28], number_overflow[60], zero fill above
  output logic [cmlex_pkg::TDATA_BITS-1:0] m_axis_tdata
);

  logic                               in_accept;
  cmlex_pkg::token_pair_t             pair;
  cmlex_pkg::token_t                  out_tok;
  logic [cmlex_pkg::LEVEL_BITS-1:0]   level;

  // A transfer is taken only when the queue can hold two more tokens.
  assign s_axis_tready = (32'(level) <= cmlex_pkg::QUEUE_DEPTH - 2);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  cmlex_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .char_in   (s_axis_tdata),
    .is_end    (s_axis_tuser),
    .pair      (pair)
  );

  cmlex_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tok   (out_tok),
    .level     (level)
  );

  assign m_axis_tdata = cmlex_pkg::TDATA_BITS'(out_tok);

  a_level_bound : assert property (@(posedge clk) disable iff (rst)
    32'(level) <= cmlex_pkg::QUEUE_DEPTH)
    else $error("token queue level exceeds its depth");

  a_second_needs_first : assert property (@(posedge clk) disable iff (rst)
    pair.valid1 |-> pair.valid0)
    else $error("second token pushed without a first");

  a_end_gives_token : assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tuser) |=> m_axis_tvalid)
    else $error("end marker produced no token");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for cminus_lexical_scanner_unit: source bytes go in over the
// input stream, and every token that comes out is checked against a scanner model kept here.
// Depends on cmlex_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb_top;
  import cmlex_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // char_in[7:0]
  logic s_axis_tuser = 1'b0;         // is_end
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // token_kind[4:0], token_line[20:5], token_length[26:21], length_overflow[27],
  // number_value[59:28], number_overflow[60]
  logic [TDATA_BITS-1:0] m_axis_tdata;

  cminus_lexical_scanner_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  string keyword_text[6] = '{"else", "if", "int", "return", "void", "while"};
  token_kind_t keyword_kind[6] = '{K_ELSE, K_IF, K_INT, K_RETURN, K_VOID, K_WHILE};
  string op_text[19] = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "=", "==", "!=",
                         ";", ",", "(", ")", "[", "]", "{", "}"};

  token_t expected_tokens[$];
  int error_count = 0;
  int items_sent = 0;
  int burst_left = 0;

  scan_state_t lex_state;
  logic [47:0] kw_bytes;
  int unsigned lex_len;
  logic [15:0] cur_line;
  logic [15:0] tok_line;
  logic [31:0] num_acc;
  logic num_sat;

  function automatic void reset_scanner();
    lex_state = S_IDLE;
    kw_bytes = '0;
    lex_len = 0;
    cur_line = 16'd1;
    tok_line = 16'd1;
    num_acc = '0;
    num_sat = 1'b0;
  endfunction

  function automatic void push_token(token_kind_t kind, logic [15:0] line, int unsigned count,
                                     logic [31:0] value, logic sat);
    token_t t;
    t.token_kind = kind;
    t.token_line = line;
    t.token_length = (count > MAX_LEXEME) ? 6'(MAX_LEXEME) : 6'(count);
    t.length_overflow = (count > MAX_LEXEME);
    t.number_value = value;
    t.number_overflow = sat;
    expected_tokens.push_back(t);
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic token_kind_t word_kind();
    bit same;
    if (lex_len > KW_BYTES) return K_ID;
    for (int j = 0; j < 6; j++) begin
      same = (keyword_text[j].len() == lex_len);
      for (int i = 0; same && i < keyword_text[j].len(); i++) begin
        if (kw_bytes[8*i +: 8] != keyword_text[j][i]) same = 1'b0;
      end
      if (same) return keyword_kind[j];
    end
    return K_ID;
  endfunction

  function automatic void finish_token(bit at_end);
    case (lex_state)
      S_IDENT: push_token(word_kind(), tok_line, lex_len, 32'd0, 1'b0);
      S_NUMBER: push_token(K_NUM, tok_line, lex_len, num_acc, num_sat);
      S_LT: push_token(K_LT, tok_line, 1, 32'd0, 1'b0);
      S_GT: push_token(K_GT, tok_line, 1, 32'd0, 1'b0);
      S_EQ: push_token(K_ASSIGN, tok_line, 1, 32'd0, 1'b0);
      S_BANG: push_token(K_BAD, tok_line, 1, 32'd0, 1'b0);
      S_SLASH: push_token(K_DIV, tok_line, 1, 32'd0, 1'b0);
      S_COMMENT, S_STAR: begin
        if (at_end) push_token(K_OPEN, tok_line, 0, 32'd0, 1'b0);
      end
      default: ;
    endcase
    lex_state = S_IDLE;
  endfunction

  function automatic void bump_line();
    if (cur_line != 16'hFFFF) cur_line++;
  endfunction

  function automatic void count_char();
    if (lex_len <= MAX_LEXEME) lex_len++;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    longint unsigned v;
    v = longint'(num_acc) * 10 + longint'(c) - longint'("0");
    if (v > 64'hFFFF_FFFF) begin
      num_acc = 32'hFFFF_FFFF;
      num_sat = 1'b1;
    end else begin
      num_acc = v[31:0];
    end
  endfunction

  function automatic void begin_token(logic [7:0] c);
    token_kind_t kind;
    tok_line = cur_line;
    if (is_alpha(c)) begin
      lex_state = S_IDENT;
      kw_bytes = {40'd0, c};
      lex_len = 1;
      return;
    end
    if (is_num(c)) begin
      lex_state = S_NUMBER;
      lex_len = 1;
      num_acc = '0;
      num_sat = 1'b0;
      add_digit(c);
      return;
    end
    case (c)
      "<": begin lex_state = S_LT; return; end
      ">": begin lex_state = S_GT; return; end
      "=": begin lex_state = S_EQ; return; end
      "!": begin lex_state = S_BANG; return; end
      "/": begin lex_state = S_SLASH; return; end
      " ", "\t", 8'h0D: return;
      "\n": begin bump_line(); return; end
      "+": kind = K_PLUS;
      "-": kind = K_MINUS;
      "*": kind = K_TIMES;
      ";": kind = K_SEMI;
      ",": kind = K_COMMA;
      "(": kind = K_LPAR;
      ")": kind = K_RPAR;
      "[": kind = K_LBRK;
      "]": kind = K_RBRK;
      "{": kind = K_LBRC;
      "}": kind = K_RBRC;
      default: kind = K_BAD;
    endcase
    push_token(kind, tok_line, 1, 32'd0, 1'b0);
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic eof);
    token_kind_t kind;
    if (eof) begin
      finish_token(1'b1);
      push_token(K_EOF, cur_line, 0, 32'd0, 1'b0);
      reset_scanner();
      return;
    end
    case (lex_state)
      S_IDENT: begin
        if (is_alpha(c)) begin
          if (lex_len < KW_BYTES) kw_bytes[8*lex_len +: 8] = c;
          count_char();
          return;
        end
      end
      S_NUMBER: begin
        if (is_num(c)) begin
          add_digit(c);
          count_char();
          return;
        end
      end
      S_LT, S_GT, S_EQ, S_BANG: begin
        if (c == "=") begin
          case (lex_state)
            S_LT: kind = K_LE;
            S_GT: kind = K_GE;
            S_EQ: kind = K_EQ;
            default: kind = K_NE;
          endcase
          lex_state = S_IDLE;
          push_token(kind, tok_line, 2, 32'd0, 1'b0);
          return;
        end
      end
      S_SLASH: begin
        if (c == "*") begin
          lex_state = S_COMMENT;
          return;
        end
      end
      S_COMMENT, S_STAR: begin
        if (c == "/" && lex_state == S_STAR) lex_state = S_IDLE;
        else lex_state = (c == "*") ? S_STAR : S_COMMENT;
        if (c == "\n") bump_line();
        return;
      end
      default: lex_state = S_IDLE;
    endcase
    finish_token(1'b0);
    begin_token(c);
  endfunction

  task automatic send_item(input logic [7:0] ch, input logic eof);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tuser <= eof;
    do @(posedge clk); while (!s_axis_tready);
    scan_byte(ch, eof);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_letters(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 51);
      send_item((r < 26) ? 8'("a" + r) : 8'("A" + r - 26), 1'b0);
    end
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
    burst_left = 0;
  endtask

  task automatic send_random_token();
    int pick;
    int n;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      send_text(keyword_text[$urandom_range(0, 5)]);
    end else if (pick < 7) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      send_letters(n);
    end else if (pick < 10) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 36) : $urandom_range(1, 5);
      send_digits(n);
    end else if (pick < 14) begin
      send_text(op_text[$urandom_range(0, 18)]);
    end else if (pick < 15) begin
      send_text("/*");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: send_text("*");
          1: send_text("/");
          2: send_text("\n");
          3: send_text(" ");
          4: send_letters(1);
          default: send_item(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end
      case ($urandom_range(0, 9))
        0: ;
        1, 2, 3: send_text("**/");
        default: send_text("*/");
      endcase
    end else if (pick < 17) begin
      case ($urandom_range(0, 3))
        0: send_text(" ");
        1: send_text("\t");
        2: send_item(8'h0D, 1'b0);
        default: send_text("\n");
      endcase
    end else if (pick < 18) begin
      send_text("!");
    end else if (pick < 19) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_end();
    end
    if ($urandom_range(0, 9) < 6) send_text(" ");
  endtask

  task automatic test_empty_file();
    send_end();
  endtask

  task automatic test_keywords_and_operators();
    send_text("if else int return void while iff While x\n");
    send_text("+-*/<<=>>===!=;,()[]{}");
    send_end();
  endtask

  task automatic test_special_cases();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    send_text("a!b! !=\t\015\nab12cd3/* x*y\n**/7/z<");
    send_end();
    send_text("z /* open\n*");
    send_end();
  endtask

  task automatic test_long_lexemes();
    send_text("return returnx ");
    send_letters(32);
    send_text(" ");
    send_letters(33);
    send_text(" ");
    send_letters(45);
    send_text(" 4294967295 4294967296 0 00 ");
    send_digits(32);
    send_text(" ");
    send_digits(33);
    send_text(" ");
    send_digits(40);
    send_end();
  endtask

  task automatic test_random_source();
    int target;
    int halfway;
    bit paused;
    target = items_sent + 800;
    halfway = items_sent + 400;
    paused = 1'b0;
    while (items_sent < target) begin
      send_random_token();
      if (!paused && items_sent >= halfway) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    send_end();
  endtask

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_tokens
    token_t got;
    token_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = token_t'(m_axis_tdata[TOKEN_BITS-1:0]);
      if (expected_tokens.size() == 0) begin
        $error("unexpected token transfer: kind %0d line %0d", got.token_kind, got.token_line);
        error_count++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", want.token_kind, got.token_kind);
        check_field("token_line", want.token_line, got.token_line);
        check_field("token_length", want.token_length, got.token_length);
        check_field("length_overflow", want.length_overflow, got.length_overflow);
        check_field("number_value", want.number_value, got.number_value);
        check_field("number_overflow", want.number_overflow, got.number_overflow);
      end
    end
  end

  int unsigned rx_cycle = 0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 257) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= (rx_cycle % 5 == 0);
      default: m_axis_tready <= (rx_cycle % 23 >= 17);
    endcase
  end

  initial begin
    int waited;
    reset_scanner();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_file();
    test_keywords_and_operators();
    test_special_cases();
    test_long_lexemes();
    test_random_source();
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_tokens.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", expected_tokens.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cmlex_pkg.sv
rtl/cmlex_core.sv
rtl/cmlex_queue.sv
rtl/cminus_lexical_scanner_unit.sv
verif/tb_top.sv
